FILE: src/tsss_pkg.sv
package tsss_pkg;

  localparam int PATTERN_MAX_DEF   = 16;
  localparam int TAG_BITS_DEF      = 16;
  localparam int POSITION_BITS_DEF = 16;

  localparam int LEN_BITS   = 5;
  localparam int FIELD_BITS = 16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TEXT  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                  command;
    logic [FIELD_BITS-1:0] index;
    logic [FIELD_BITS-1:0] tag_code;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic                  match_found;
    logic [FIELD_BITS-1:0] match_position;
    logic                  search_finished;
    logic                  no_match;
  } result_t;

endpackage

FILE: src/tag_sequence_substring_search.sv
// Streamed leftmost substring search over tag codes.
// Input channel (in_*): one item per handshake. tuser carries the command:
// load a pattern slot, a text element, or start a new search. tlast marks
// the final text element of a search. Every accepted item gives exactly one
// result item on the output channel (out_*), in order.
// cfg_wr_en/cfg_wr_data set the pattern length; write it only while idle.
// An accepted item sits in the input register; the result register loads
// its result when the output channel can advance. Throughput: one item per
// cycle while the receiver takes results; the per-item state update (text
// shift line and its compare matrix against the stored pattern) is worked
// out combinationally between the two registers.
// When the receiver stalls, the result register holds, the input register
// fills, and in_tready drops; nothing is lost or repeated.
// Reset (rst_n low at a clock edge, synchronous) empties both registers,
// clears the search state and sets the pattern length to 1. Pattern slots
// are not cleared and must be loaded before use.
module tag_sequence_substring_search #(
  parameter int PATTERN_MAX   = tsss_pkg::PATTERN_MAX_DEF,
  parameter int TAG_BITS      = tsss_pkg::TAG_BITS_DEF,
  parameter int POSITION_BITS = tsss_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // index[15:0], tag_code[31:16]
  input  logic [1:0]  in_tuser,   // command[1:0]
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // match_found[0], match_position[16:1], no_match[17]
  output logic        out_tlast,  // search_finished
  input  logic        cfg_wr_en,
  input  logic [tsss_pkg::LEN_BITS-1:0] cfg_wr_data
);
  import tsss_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  item_t   in_item;
  logic    adv;
  logic    fire;
  logic    in_fire;
  result_t core_res;
  result_t out_res;

  assign in_item.command  = cmd_t'(in_tuser);
  assign in_item.index    = in_tdata[15:0];
  assign in_item.tag_code = in_tdata[31:16];
  assign in_item.last     = in_tlast;

  assign adv       = !out_tvalid || out_tready;
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  tsss_match_core #(
    .PATTERN_MAX   (PATTERN_MAX),
    .TAG_BITS      (TAG_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (s1_item_r),
    .result      (core_res)
  );

  tsss_out_reg u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (fire),
    .take  (out_tready),
    .din   (core_res),
    .valid (out_tvalid),
    .dout  (out_res)
  );

  assign out_tdata = {6'd0, out_res.no_match, out_res.match_position, out_res.match_found};
  assign out_tlast = out_res.search_finished;

  a_nomatch_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tlast)
    else $error("no_match without search_finished");

  a_found_xor_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[17]))
    else $error("match_found and no_match together");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("item advanced without a result");

  a_non_text_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (s1_item_r.command != CMD_TEXT) |=> !out_tlast && !out_tdata[0])
    else $error("non-text item flagged a match or end");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_tvalid && !out_tready)
    else $error("input stalled without a full pipeline");

endmodule

FILE: src/tsss_match_core.sv
module tsss_match_core #(
  parameter int PATTERN_MAX   = 16,
  parameter int TAG_BITS      = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [tsss_pkg::LEN_BITS-1:0] cfg_wr_data,
  input  logic                     fire,
  input  tsss_pkg::item_t          item,
  output tsss_pkg::result_t        result
);
  import tsss_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX);
  localparam int FW = $clog2(PATTERN_MAX + 1);
  localparam int WB = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;

  logic [LEN_BITS-1:0]      pattern_length_r;
  logic [TAG_BITS-1:0]      pattern_r   [PATTERN_MAX];
  logic [TAG_BITS-1:0]      pattern_nxt [PATTERN_MAX];
  logic [TAG_BITS-1:0]      window_r    [PATTERN_MAX];
  logic [TAG_BITS-1:0]      window_nxt  [PATTERN_MAX];
  // eq_r[i][j]: window element i equals pattern slot j
  logic [PATTERN_MAX-1:0]   eq_r        [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   eq_nxt      [PATTERN_MAX];
  logic [FW-1:0]            fill_r, fill_nxt, fill_inc;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     found_r, found_nxt;
  logic [POSITION_BITS-1:0] mstart_r, mstart_nxt;

  logic [TAG_BITS-1:0]      tag;
  logic [LW-1:0]            lenm1;
  logic [LW-1:0]            slot;
  logic                     slot_ok;
  logic [PATTERN_MAX-1:0]   hit_len;
  logic                     hit;
  logic                     finished;
  logic [WB-1:0]            idx_w;
  logic [POSITION_BITS-1:0] start_pos;
  logic [POSITION_BITS-1:0] lenm1_p;

  assign tag     = TAG_BITS'(item.tag_code);
  assign slot    = LW'(item.index);
  assign slot_ok = item.index < FIELD_BITS'(PATTERN_MAX);
  assign lenm1_p = POSITION_BITS'(lenm1);
  assign idx_w   = WB'(item.index);

  always_comb begin
    logic [7:0] len8;
    len8 = 8'(pattern_length_r);
    if (len8 == 8'd0) begin
      lenm1 = '0;
    end else if (len8 > 8'(PATTERN_MAX)) begin
      lenm1 = LW'(PATTERN_MAX - 1);
    end else begin
      lenm1 = LW'(len8 - 8'd1);
    end
  end

  always_comb begin
    if (idx_w > WB'({POSITION_BITS{1'b1}})) begin
      start_pos = '1;
    end else begin
      start_pos = POSITION_BITS'(idx_w);
    end
  end

  assign fill_inc = (fill_r < FW'(PATTERN_MAX)) ? fill_r + FW'(1) : fill_r;

  always_comb begin
    pattern_nxt = pattern_r;
    window_nxt  = window_r;
    eq_nxt      = eq_r;
    fill_nxt    = fill_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    mstart_nxt  = mstart_r;
    hit_len     = '0;
    hit         = 1'b0;
    finished    = 1'b0;

    case (item.command)
      CMD_LOAD: begin
        if (slot_ok) begin
          pattern_nxt[slot] = tag;
          for (int i = 0; i < PATTERN_MAX; i++) begin
            eq_nxt[i][slot] = (window_r[i] == tag);
          end
        end
      end
      CMD_TEXT: begin
        window_nxt[0] = tag;
        for (int i = 1; i < PATTERN_MAX; i++) begin
          window_nxt[i] = window_r[i-1];
          eq_nxt[i]     = eq_r[i-1];
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
          eq_nxt[0][j] = (pattern_r[j] == tag);
        end
        fill_nxt = fill_inc;
        // one AND per candidate length over fixed matrix bits
        for (int l = 0; l < PATTERN_MAX; l++) begin
          hit_len[l] = 1'b1;
          for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k <= l) begin
              hit_len[l] = hit_len[l] & eq_nxt[k][l-k];
            end
          end
        end
        if (!found_r && hit_len[lenm1] && (8'(fill_inc) > 8'(lenm1))) begin
          hit        = 1'b1;
          found_nxt  = 1'b1;
          mstart_nxt = (pos_r >= lenm1_p) ? pos_r - lenm1_p : '0;
        end
        if (pos_r != '1) begin
          pos_nxt = pos_r + POSITION_BITS'(1);
        end
        finished = item.last;
      end
      CMD_START: begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
          window_nxt[i] = '0;
        end
        fill_nxt   = '0;
        pos_nxt    = start_pos;
        found_nxt  = 1'b0;
        mstart_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign result.match_found     = hit;
  assign result.match_position  = FIELD_BITS'(mstart_nxt);
  assign result.search_finished = finished;
  assign result.no_match        = finished && !found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= LEN_BITS'(1);
    end else if (cfg_wr_en) begin
      pattern_length_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window_r[i] <= '0;
      end
      fill_r   <= '0;
      pos_r    <= '0;
      found_r  <= 1'b0;
      mstart_r <= '0;
    end else if (fire) begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
      found_r  <= found_nxt;
      mstart_r <= mstart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pattern_r <= pattern_nxt;
      eq_r      <= eq_nxt;
    end
  end

endmodule

FILE: src/tsss_out_reg.sv
module tsss_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              take,
  input  tsss_pkg::result_t din,
  output logic              valid,
  output tsss_pkg::result_t dout
);
  import tsss_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign valid = valid_r;
  assign dout  = data_r;

endmodule
